// ----- sv/slipfd_pkg.sv -----
// Shared types and constants for the SLIP frame decoder.
`default_nettype none
package slipfd_pkg;

	localparam int MAX_FRAME   = 512;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 10;
	localparam int CNT_W       = $clog2(MAX_FRAME + 1);
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (BYTE_W + LEN_W + 2);

	localparam logic [BYTE_W-1:0] FRAME_END = 8'hC0;
	localparam logic [BYTE_W-1:0] FRAME_ESC = 8'hDB;
	localparam logic [BYTE_W-1:0] XLAT_END  = 8'hDC;
	localparam logic [BYTE_W-1:0] XLAT_ESC  = 8'hDD;

	typedef enum logic {
		OP_STORE,
		OP_END
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [BYTE_W-1:0]   data;
		logic                bad;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last;
		logic [LEN_W-1:0]  frame_length;
		logic              truncated;
		logic              bad_escape;
	} result_t;

endpackage
`default_nettype wire

// ----- sv/slipfd_front.sv -----
// Front end: accepts raw bytes, resolves escapes, issues store/end ops.
`default_nettype none
module slipfd_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  enable,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire  [slipfd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] in_byte
	input  wire  slipfd_pkg::q_status_t          q_status,
	output logic                                 push,
	output slipfd_pkg::op_t                      op
);
	import slipfd_pkg::*;

	logic              esc_q;
	logic              esc_d;
	logic              accept;
	logic [BYTE_W-1:0] in_byte;

	assign s_axis_tready = !q_status.full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_byte       = s_axis_tdata[BYTE_W-1:0];

	always_comb begin
		push     = 1'b0;
		op.kind  = OP_STORE;
		op.data  = in_byte;
		op.bad   = 1'b0;
		esc_d    = esc_q;
		if (accept && enable) begin
			if (esc_q) begin
				esc_d = 1'b0;
				push  = 1'b1;
				priority if (in_byte == XLAT_END) begin
					op.data = FRAME_END;
				end else if (in_byte == XLAT_ESC) begin
					op.data = FRAME_ESC;
				end else begin
					op.bad = 1'b1;
				end
			end else if (in_byte == FRAME_END) begin
				push    = 1'b1;
				op.kind = OP_END;
			end else if (in_byte == FRAME_ESC) begin
				esc_d = 1'b1;
			end else begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
		end else begin
			esc_q <= esc_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/slipfd_queue.sv -----
// Short op queue between front and back ends.
`default_nettype none
module slipfd_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  wire slipfd_pkg::op_t   push_op,
	input  wire                    pop,
	output slipfd_pkg::op_t        head_op,
	output slipfd_pkg::q_status_t  status
);
	import slipfd_pkg::*;

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_op      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/slipfd_back.sv -----
// Back end: frame state, one-byte holdback and output register.
`default_nettype none
module slipfd_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire slipfd_pkg::op_t       head_op,
	input  wire slipfd_pkg::q_status_t q_status,
	output logic                       pop,
	output logic                       out_valid,
	input  wire                        out_ready,
	output slipfd_pkg::result_t        out_res
);
	import slipfd_pkg::*;

	logic [BYTE_W-1:0] held_byte_q;
	logic              held_valid_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic              bad_q;
	logic              out_valid_q;
	result_t           out_res_q;

	logic              advance;
	logic              emit;
	result_t           res;
	logic [BYTE_W-1:0] held_byte_d;
	logic              held_valid_d;
	logic [CNT_W-1:0]  count_d;
	logic              ovf_d;
	logic              bad_d;

	assign advance   = !out_valid_q || out_ready;
	assign pop       = advance && !q_status.empty;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_comb begin
		emit             = 1'b0;
		res.data_byte    = held_byte_q;
		res.last         = 1'b0;
		res.frame_length = '0;
		res.truncated    = 1'b0;
		res.bad_escape   = 1'b0;
		held_byte_d      = held_byte_q;
		held_valid_d     = held_valid_q;
		count_d          = count_q;
		ovf_d            = ovf_q;
		bad_d            = bad_q;
		if (pop) begin
			unique case (head_op.kind)
				OP_STORE: begin
					bad_d = bad_q | head_op.bad;
					if (count_q >= CNT_W'(MAX_FRAME)) begin
						ovf_d = 1'b1;
					end else begin
						emit         = held_valid_q;
						held_byte_d  = head_op.data;
						held_valid_d = 1'b1;
						count_d      = count_q + CNT_W'(1);
					end
				end
				OP_END: begin
					if (held_valid_q && count_q != '0) begin
						emit             = 1'b1;
						res.last         = 1'b1;
						res.frame_length = LEN_W'(count_q);
						res.truncated    = ovf_q;
						res.bad_escape   = bad_q;
						held_byte_d      = '0;
						held_valid_d     = 1'b0;
						count_d          = '0;
						ovf_d            = 1'b0;
						bad_d            = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			bad_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			held_byte_q  <= held_byte_d;
			held_valid_q <= held_valid_d;
			count_q      <= count_d;
			ovf_q        <= ovf_d;
			bad_q        <= bad_d;
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/slip_frame_decoder_unit.sv -----
// Top level of the SLIP frame decoder: config register, front, queue, back.
// Throughput: one input word per cycle; s_axis_tready drops only when the op queue is full.
// After the word that releases a payload byte from the one-byte holdback (the next stored byte
// or the closing END) is accepted, that word passes the op queue and the byte leaves via the output register.
// Reset (arst_n low): enable clears, escape and frame state clear, queue and output empty.
`default_nettype none
module slip_frame_decoder_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire                                   cfg_data,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire  [slipfd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] in_byte
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// [7:0] data_byte, [17:8] frame_length, [18] truncated, [19] bad_escape, rest 0
	output logic [slipfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                  m_axis_tlast
);
	import slipfd_pkg::*;

	logic      enable_q;
	logic      push;
	logic      pop;
	op_t       push_op;
	op_t       head_op;
	q_status_t q_status;
	result_t   res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	slipfd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.enable        (enable_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_status      (q_status),
		.push          (push),
		.op            (push_op)
	);

	slipfd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.status  (q_status)
	);

	slipfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_op   (head_op),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tlast = res.last;
	assign m_axis_tdata = {OUT_PAD_W'(0), res.bad_escape, res.truncated,
		res.frame_length, res.data_byte};

	a_last_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> res.frame_length != '0)
		else $error("frame closed with zero length");

	a_summary_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |->
			res.frame_length == '0 && !res.truncated && !res.bad_escape)
		else $error("summary fields set on non-last word");

	a_no_push_when_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		!enable_q |-> !push)
		else $error("op queued while disabled");

	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue both full and empty");

endmodule
`default_nettype wire
